>>> src/sgaas_pkg.sv
// Package: types, constants and saturating helpers for the semi-global alignment scorer.
package sgaas_pkg;

    localparam int MAX_QUERY_DEF = 128;
    localparam int ALPHABET_DEF  = 24;

    localparam logic signed [7:0] SAT_LO = 8'sh80;
    localparam logic signed [7:0] SAT_HI = 8'sh7f;

    localparam logic [1:0] OP_TABLE = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_DB    = 2'd2;
    localparam logic [1:0] OP_IDLE  = 2'd3;

    localparam logic [1:0] CFG_GAP_OPEN   = 2'd0;
    localparam logic [1:0] CFG_GAP_EXTEND = 2'd1;
    localparam logic [1:0] CFG_QUERY_LEN  = 2'd2;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [4:0]        table_row;
        logic [4:0]        table_col;
        logic signed [7:0] table_score;
        logic [6:0]        query_position;
        logic [4:0]        residue;
        logic              last_residue;
    } t_cmd;

    typedef struct packed {
        logic signed [7:0] score;
        logic              saturated;
    } t_result;

    // wavefront word handed from one row cell to the next
    typedef struct packed {
        logic signed [7:0] h;
        logic signed [7:0] hold;
        logic signed [7:0] f;
        logic signed [7:0] colmax;
        logic              sat;
    } t_tok;

    function automatic logic signed [7:0] sat8(input logic signed [9:0] v);
        if (v > 10'sd127) begin
            return SAT_HI;
        end else if (v < -10'sd128) begin
            return SAT_LO;
        end
        return v[7:0];
    endfunction

    function automatic logic signed [7:0] max8(input logic signed [7:0] a,
                                               input logic signed [7:0] b);
        return (a > b) ? a : b;
    endfunction

endpackage

>>> src/sgaas_cell.sv
// One query row cell: holds H and E of its row and applies the Gotoh step.
module sgaas_cell (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_clr,
    input  logic signed [7:0]        i_s,
    input  logic [6:0]               i_go,
    input  logic [6:0]               i_ge,
    input  sgaas_pkg::t_tok          i_tok,
    output sgaas_pkg::t_tok          o_tok
);
    import sgaas_pkg::*;

    logic signed [7:0] r_h, r_e;
    logic signed [7:0] n_e, n_f, n_h;
    t_tok              r_tok;

    always_comb begin
        n_e = max8(sat8(10'(r_e) - $signed({3'b000, i_ge})),
                   sat8(10'(r_h) - $signed({3'b000, i_go})));
        n_f = max8(sat8(10'(i_tok.f) - $signed({3'b000, i_ge})),
                   sat8(10'(i_tok.h) - $signed({3'b000, i_go})));
        n_h = max8(sat8(10'(i_tok.hold) + 10'(i_s)), max8(n_e, n_f));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_h <= 8'sd0;
            r_e <= SAT_LO;
        end else if (i_en) begin
            r_h <= n_h;
            r_e <= n_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tok.h      <= n_h;
            r_tok.hold   <= r_h;
            r_tok.f      <= n_f;
            r_tok.colmax <= max8(i_tok.colmax, n_h);
            r_tok.sat    <= i_tok.sat || (n_h == SAT_LO) || (n_h == SAT_HI);
        end
    end

    assign o_tok = r_tok;

endmodule

>>> src/semiglobal_affine_align_score_unit.sv
// Top level: command decode, query and table memories, row cell chain, result.
// A database word keeps busy high while it passes the query and table read
// stages and its wavefront walks the row cell chain. The score word is shown
// for one cycle on o_done; the receiver cannot stall it.
module semiglobal_affine_align_score_unit #(
    parameter int MAX_QUERY = sgaas_pkg::MAX_QUERY_DEF,
    parameter int ALPHABET  = sgaas_pkg::ALPHABET_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  sgaas_pkg::t_cmd      i_cmd,
    output logic                 o_done,
    output sgaas_pkg::t_result   o_result,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [7:0]           i_cfg_data
);
    import sgaas_pkg::*;

    localparam int QW    = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1;
    localparam int TD    = ALPHABET * ALPHABET;
    localparam int TW    = $clog2(TD);
    localparam logic [10:0] MQ = 11'(MAX_QUERY);
    localparam logic [5:0]  AL = 6'(ALPHABET);

    logic [6:0] r_go, r_ge;
    logic [7:0] r_ql;

    logic [4:0]        q_mem [MAX_QUERY];
    logic signed [7:0] t_mem [TD];

    logic              r_active, r_iss_on, r_last;
    logic [4:0]        r_db;
    logic [QW-1:0]     r_issue;
    logic              r_v1, r_v2, r_v3;
    logic [QW-1:0]     r_row1, r_row2, r_row3;
    logic [4:0]        r_q;
    logic              r_inr;
    logic signed [7:0] r_tab;
    logic signed [7:0] r_best;
    logic              r_sat;
    logic              r_done;
    t_result           r_res;

    logic [10:0]   eff_rows;
    logic [QW-1:0] last_row;
    logic          accept, fin, clr;
    t_tok          tok_in  [MAX_QUERY];
    t_tok          tok_out [MAX_QUERY];
    t_tok          border, tok_end;
    logic signed [7:0] new_best, s_val;
    logic          sat_all;

    assign accept      = i_start && !r_active;
    assign o_busy      = r_active;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (r_ql == 8'd0) begin
            eff_rows = 11'd1;
        end else if ({3'b000, r_ql} > MQ) begin
            eff_rows = MQ;
        end else begin
            eff_rows = {3'b000, r_ql};
        end
        last_row = QW'(eff_rows - 11'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_go <= 7'd10;
            r_ge <= 7'd1;
            r_ql <= 8'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_GAP_OPEN:   r_go <= i_cfg_data[6:0];
                CFG_GAP_EXTEND: r_ge <= i_cfg_data[6:0];
                CFG_QUERY_LEN:  r_ql <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (accept && i_cmd.opcode == OP_QUERY && {4'b0000, i_cmd.query_position} < MQ) begin
            q_mem[QW'(i_cmd.query_position)] <= i_cmd.residue;
        end
        if (accept && i_cmd.opcode == OP_TABLE && {1'b0, i_cmd.table_row} < AL
                && {1'b0, i_cmd.table_col} < AL) begin
            t_mem[TW'(32'(i_cmd.table_row) * ALPHABET + 32'(i_cmd.table_col))]
                <= i_cmd.table_score;
        end
        r_q   <= q_mem[r_issue];
        r_tab <= t_mem[TW'(32'(r_db) * ALPHABET + 32'(r_q))];
        r_inr <= ({1'b0, r_db} < AL) && ({1'b0, r_q} < AL);
    end

    always_ff @(posedge i_clk) begin
        r_row1 <= r_issue;
        r_row2 <= r_row1;
        r_row3 <= r_row2;
    end

    assign tok_end  = tok_out[r_row3];
    assign fin      = r_v3 && (r_row3 == last_row);
    assign clr      = fin && r_last;
    assign new_best = max8(r_best, tok_end.h);
    assign sat_all  = r_sat || tok_end.sat;
    assign s_val    = r_inr ? r_tab : 8'sd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_iss_on <= 1'b0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_done   <= 1'b0;
            r_best   <= SAT_LO;
            r_sat    <= 1'b0;
            r_issue  <= '0;
        end else begin
            r_done <= 1'b0;
            r_v1   <= r_iss_on;
            r_v2   <= r_v1;
            r_v3   <= r_v2;
            if (accept && i_cmd.opcode == OP_DB) begin
                r_active <= 1'b1;
                r_iss_on <= 1'b1;
                r_issue  <= '0;
                r_db     <= i_cmd.residue;
                r_last   <= i_cmd.last_residue;
            end else if (r_iss_on) begin
                if (r_issue == last_row) begin
                    r_iss_on <= 1'b0;
                end else begin
                    r_issue <= r_issue + QW'(1);
                end
            end
            if (fin) begin
                r_active <= 1'b0;
                if (r_last) begin
                    r_done          <= 1'b1;
                    r_res.saturated <= sat_all;
                    r_res.score     <= sat_all ? SAT_HI : max8(new_best, tok_end.colmax);
                    r_best          <= SAT_LO;
                    r_sat           <= 1'b0;
                end else begin
                    r_best <= new_best;
                    r_sat  <= sat_all;
                end
            end
        end
    end

    assign border.h      = 8'sd0;
    assign border.hold   = 8'sd0;
    assign border.f      = SAT_LO;
    assign border.colmax = SAT_LO;
    assign border.sat    = 1'b0;

    for (genvar g = 0; g < MAX_QUERY; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign tok_in[g] = border;
        end else begin : g_rest
            assign tok_in[g] = tok_out[g-1];
        end
        sgaas_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (r_v2 && (r_row2 == QW'(g))),
            .i_clr   (clr),
            .i_s     (s_val),
            .i_go    (r_go),
            .i_ge    (r_ge),
            .i_tok   (tok_in[g]),
            .o_tok   (tok_out[g])
        );
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule
